FILE: src/line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// line_rasterizer_assert.svh
// Assertion macros shared by the line rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths, register indexes and the queued line command type.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  localparam int COORD_W             = 6;
  localparam int COLOR_W             = 8;
  localparam int REG_W               = 7;
  localparam int CNT_W               = 7;
  localparam int ERR_W               = 9;
  localparam int CFG_IDX_W           = 1;
  localparam int DEFAULT_SURFACE_DIM = 64;
  localparam int QDEPTH              = 2;
  localparam int QPTR_W              = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 1'b1;

  // One classified line, ready for the stepper.
  typedef struct packed {
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    y_down;
    logic                    steep;
    logic signed [ERR_W-1:0] err0;
    logic [COORD_W-1:0]      last_idx;
    logic [COLOR_W-1:0]      color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: src/lr_cmd_queue.sv
// ----------------------------------------------------------------------------
// lr_cmd_queue
// Small register FIFO of classified line commands between front and stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lr_pkg::cmd_t  push_cmd,
  input  wire logic          pop,
  output lr_pkg::cmd_t       head,
  output lr_pkg::q_stat_t    stat
);
  import lr_pkg::*;

  cmd_t               entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.full  = (fill == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (fill == '0);

endmodule

`default_nettype wire

FILE: src/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Accepts a line request and classifies it: walk origin, deltas, step
// direction, steepness, starting error term and dot count.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_front #(
  parameter int SURFACE_DIM = lr_pkg::DEFAULT_SURFACE_DIM
) (
  input  wire logic [lr_pkg::COORD_W-1:0] start_x,
  input  wire logic [lr_pkg::COORD_W-1:0] start_y,
  input  wire logic [lr_pkg::COORD_W-1:0] end_x,
  input  wire logic [lr_pkg::COORD_W-1:0] end_y,
  input  wire logic [lr_pkg::COLOR_W-1:0] pen_color,
  output lr_pkg::cmd_t                    cmd
);
  import lr_pkg::*;

  localparam logic [CNT_W-1:0] DOT_LIMIT = CNT_W'(SURFACE_DIM);

  logic                    swap;
  logic                    y_neg;
  logic [COORD_W-1:0]      dx;
  logic [COORD_W-1:0]      dy;
  logic signed [COORD_W+1:0] diff;
  logic signed [COORD_W+1:0] diff_adj;
  logic signed [COORD_W+1:0] half;
  logic [CNT_W-1:0]        total;
  logic [CNT_W-1:0]        dots;

  always_comb begin
    swap  = (end_x < start_x);
    y_neg = (end_y < start_y);
    dx    = swap  ? (start_x - end_x) : (end_x - start_x);
    dy    = y_neg ? (start_y - end_y) : (end_y - start_y);

    // Halve dx - dy with truncation toward zero: bias negatives by one first.
    diff     = $signed({2'b00, dx}) - $signed({2'b00, dy});
    diff_adj = diff + $signed({{(COORD_W+1){1'b0}}, diff[COORD_W+1]});
    half     = diff_adj >>> 1;

    cmd.steep  = (dy > dx);
    total      = cmd.steep ? ({1'b0, dy} + 1'b1) : ({1'b0, dx} + 1'b1);
    dots       = (total > DOT_LIMIT) ? DOT_LIMIT : total;

    cmd.x0       = swap ? end_x : start_x;
    cmd.y0       = swap ? end_y : start_y;
    cmd.dx       = dx;
    cmd.dy       = dy;
    cmd.y_down   = y_neg ^ swap;
    cmd.err0     = {{(ERR_W-COORD_W-2){half[COORD_W+1]}}, half};
    cmd.last_idx = COORD_W'(dots - 1'b1);
    cmd.color    = pen_color;
  end

endmodule

`default_nettype wire

FILE: src/lr_stepper.sv
// ----------------------------------------------------------------------------
// lr_stepper
// Walks one queued line, one dot per cycle, and registers each dot out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_rasterizer_assert.svh"

module lr_stepper (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lr_pkg::cmd_t               head,
  input  wire lr_pkg::q_stat_t            q_stat,
  output logic                            pop,
  input  wire logic [lr_pkg::REG_W-1:0]   surface_width,
  input  wire logic [lr_pkg::REG_W-1:0]   surface_height,
  output logic                            dot_strobe,
  output logic [lr_pkg::COORD_W-1:0]      dot_x,
  output logic [lr_pkg::COORD_W-1:0]      dot_y,
  output logic [lr_pkg::COLOR_W-1:0]      dot_color,
  output logic                            visible,
  output logic                            last_dot
);
  import lr_pkg::*;

  logic                    active;
  logic [COORD_W-1:0]      cur_x;
  logic [COORD_W-1:0]      cur_y;
  logic signed [ERR_W-1:0] err;
  logic [COORD_W-1:0]      remain;
  logic [COORD_W-1:0]      dx;
  logic [COORD_W-1:0]      dy;
  logic                    y_down;
  logic                    steep;
  logic [COLOR_W-1:0]      color;

  logic                    load;
  logic signed [ERR_W-1:0] err_a;
  logic [COORD_W-1:0]      x_next;
  logic [COORD_W-1:0]      y_next;
  logic signed [ERR_W-1:0] err_next;
  logic [COORD_W-1:0]      y_stepped;

  assign load = !active || (remain == '0);
  assign pop  = load && !q_stat.empty;

  always_comb begin
    y_stepped = y_down ? (cur_y - 1'b1) : (cur_y + 1'b1);
    if (!steep) begin
      err_a  = err - $signed({{(ERR_W-COORD_W){1'b0}}, dy});
      x_next = cur_x + 1'b1;
      if (err_a < 0) begin
        err_next = err_a + $signed({{(ERR_W-COORD_W){1'b0}}, dx});
        y_next   = y_stepped;
      end else begin
        err_next = err_a;
        y_next   = cur_y;
      end
    end else begin
      err_a  = err + $signed({{(ERR_W-COORD_W){1'b0}}, dx});
      y_next = y_stepped;
      if (err_a > 0) begin
        err_next = err_a - $signed({{(ERR_W-COORD_W){1'b0}}, dy});
        x_next   = cur_x + 1'b1;
      end else begin
        err_next = err_a;
        x_next   = cur_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      dot_strobe <= 1'b0;
    end else begin
      dot_strobe <= active;
      if (load) begin
        active <= !q_stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      dot_x     <= cur_x;
      dot_y     <= cur_y;
      dot_color <= color;
      visible   <= ({1'b0, cur_x} < surface_width) && ({1'b0, cur_y} < surface_height);
      last_dot  <= (remain == '0);
    end
    if (pop) begin
      cur_x  <= head.x0;
      cur_y  <= head.y0;
      err    <= head.err0;
      remain <= head.last_idx;
      dx     <= head.dx;
      dy     <= head.dy;
      y_down <= head.y_down;
      steep  <= head.steep;
      color  <= head.color;
    end else if (active) begin
      cur_x  <= x_next;
      cur_y  <= y_next;
      err    <= err_next;
      remain <= remain - 1'b1;
    end
  end

  `LR_ASSERT_NEXT(a_idle_no_dot, !active, !dot_strobe, "dot emitted while stepper idle")
  `LR_ASSERT_NEXT(a_walk_continues, active && (remain != '0), dot_strobe && active,
                  "line walk stopped before its last dot")
  `LR_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "command taken from empty queue")
  `LR_ASSERT_NOW(a_mid_dot_active, dot_strobe && !last_dot, active,
                 "stepper went idle in the middle of a line")

endmodule

`default_nettype wire

FILE: src/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Integer error-term line rasterizer with surface clipping.
// ----------------------------------------------------------------------------
// A line request (two endpoints and a pen color) is taken at a rising edge
// where start is high and busy is low. The line produces max(|dx|,|dy|)+1
// dots, capped at SURFACE_DIM, one dot per clock cycle on dot_strobe; the
// receiver cannot stall, so every strobed dot must be captured in that cycle.
// With the stepper free, a request's first dot follows the queue and walk
// registers. The single error-term stepper sets the rate: it holds a line
// until its last dot, and the next queued line follows with no gap. Requests
// are classified up front and held in a two-entry queue, so busy rises only
// when two lines wait behind the one being drawn. visible is low for dots
// outside surface_width by surface_height; last_dot marks the final dot of
// each line. The surface registers are written through cfg_we, cfg_index and
// cfg_data and should only change while no line is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer #(
  parameter int SURFACE_DIM = lr_pkg::DEFAULT_SURFACE_DIM
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lr_pkg::REG_W-1:0]     cfg_data,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [lr_pkg::COORD_W-1:0]   start_x,
  input  wire logic [lr_pkg::COORD_W-1:0]   start_y,
  input  wire logic [lr_pkg::COORD_W-1:0]   end_x,
  input  wire logic [lr_pkg::COORD_W-1:0]   end_y,
  input  wire logic [lr_pkg::COLOR_W-1:0]   pen_color,
  output logic                              dot_strobe,
  output logic [lr_pkg::COORD_W-1:0]        dot_x,
  output logic [lr_pkg::COORD_W-1:0]        dot_y,
  output logic [lr_pkg::COLOR_W-1:0]        dot_color,
  output logic                              visible,
  output logic                              last_dot
);
  import lr_pkg::*;

  logic [REG_W-1:0] surface_width;
  logic [REG_W-1:0] surface_height;
  cmd_t             new_cmd;
  cmd_t             head;
  q_stat_t          q_stat;
  logic             push;
  logic             pop;

  // Clip size registers. Both come out of reset at the full surface size.
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= REG_W'(SURFACE_DIM);
      surface_height <= REG_W'(SURFACE_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        CFG_SURFACE_HEIGHT: surface_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A request enters the queue whenever the queue has room.
  assign busy = q_stat.full;
  assign push = start && !busy;

  lr_front #(
    .SURFACE_DIM(SURFACE_DIM)
  ) u_front (
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .pen_color(pen_color),
    .cmd      (new_cmd)
  );

  lr_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(new_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  // The stepper pulls the next line from the queue on the cycle it registers the
  // last dot of the current one, so consecutive lines stream without a bubble.
  lr_stepper u_stepper (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .surface_width (surface_width),
    .surface_height(surface_height),
    .dot_strobe    (dot_strobe),
    .dot_x         (dot_x),
    .dot_y         (dot_y),
    .dot_color     (dot_color),
    .visible       (visible),
    .last_dot      (last_dot)
  );

endmodule

`default_nettype wire
